// ----- design/gsus_pkg.sv -----
`default_nettype none
package gsus_pkg;

  localparam int STEP_W = 32;
  localparam int MUL_W = 22;
  localparam int SEC_W = STEP_W + MUL_W;
  localparam int ODD_W = 10;
  localparam int PROD_W = 16 + ODD_W;

  localparam logic [3:0] CAND_COUNT = 4'd10;

  // Unit codes, named after their meaning in the candidate table.
  localparam logic [3:0] UC_MINUTE = 4'd0;
  localparam logic [3:0] UC_HOUR = 4'd1;
  localparam logic [3:0] UC_DAY = 4'd2;
  localparam logic [3:0] UC_MONTH = 4'd3;
  localparam logic [3:0] UC_3HOUR = 4'd10;
  localparam logic [3:0] UC_6HOUR = 4'd11;
  localparam logic [3:0] UC_12HOUR = 4'd12;
  localparam logic [3:0] UC_QHOUR = 4'd13;
  localparam logic [3:0] UC_HALFHOUR = 4'd14;
  localparam logic [3:0] UC_SECOND = 4'd15;

  typedef struct packed {
    logic [31:0] start_step;
    logic [31:0] end_step;
    logic [3:0]  step_unit_code;
    logic [7:0]  current_unit;
    logic [15:0] limit_value;
    logic        instant_mode;
  } in_t;

  typedef struct packed {
    logic        status;
    logic [3:0]  chosen_unit;
    logic [15:0] p1_value;
    logic [15:0] p2_value;
  } out_t;

  typedef struct packed {
    logic       load;
    logic       mult;
    logic       issue;
    logic [3:0] idx;
    logic       res_pass;
    logic       res_fail;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic unit_bad;
    logic hit;
  } sts_t;

  // Seconds per step unit code; zero marks a code with no defined length.
  // The last three codes are ordered differently from the candidate table.
  function automatic logic [MUL_W-1:0] step_secs(input logic [3:0] code);
    logic [MUL_W-1:0] s;
    case (code)
      UC_MINUTE:   s = MUL_W'(60);
      UC_HOUR:     s = MUL_W'(3600);
      UC_DAY:      s = MUL_W'(86400);
      UC_MONTH:    s = MUL_W'(2592000);
      UC_3HOUR:    s = MUL_W'(10800);
      UC_6HOUR:    s = MUL_W'(21600);
      UC_12HOUR:   s = MUL_W'(43200);
      UC_QHOUR:    s = MUL_W'(1);
      UC_HALFHOUR: s = MUL_W'(900);
      UC_SECOND:   s = MUL_W'(1800);
      default:     s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] cand_code(input logic [3:0] pos);
    logic [3:0] c;
    case (pos)
      4'd0:    c = UC_HOUR;
      4'd1:    c = UC_MINUTE;
      4'd2:    c = UC_3HOUR;
      4'd3:    c = UC_6HOUR;
      4'd4:    c = UC_12HOUR;
      4'd5:    c = UC_DAY;
      4'd6:    c = UC_MINUTE;
      4'd7:    c = UC_QHOUR;
      4'd8:    c = UC_HALFHOUR;
      4'd9:    c = UC_SECOND;
      default: c = UC_HOUR;
    endcase
    return c;
  endfunction

  // First position of a unit code in the candidate list; unknown codes start at 0.
  function automatic logic [3:0] start_pos(input logic [7:0] cur);
    logic [3:0] p;
    case (cur)
      8'(UC_MINUTE):   p = 4'd1;
      8'(UC_3HOUR):    p = 4'd2;
      8'(UC_6HOUR):    p = 4'd3;
      8'(UC_12HOUR):   p = 4'd4;
      8'(UC_DAY):      p = 4'd5;
      8'(UC_QHOUR):    p = 4'd7;
      8'(UC_HALFHOUR): p = 4'd8;
      8'(UC_SECOND):   p = 4'd9;
      default:         p = 4'd0;
    endcase
    return p;
  endfunction

  // Each candidate length is split as 2^shift times an odd factor.
  function automatic logic [2:0] unit_shift(input logic [3:0] code);
    logic [2:0] x;
    case (code)
      UC_MINUTE:   x = 3'd2;
      UC_HOUR:     x = 3'd4;
      UC_DAY:      x = 3'd7;
      UC_3HOUR:    x = 3'd4;
      UC_6HOUR:    x = 3'd5;
      UC_12HOUR:   x = 3'd6;
      UC_QHOUR:    x = 3'd2;
      UC_HALFHOUR: x = 3'd3;
      default:     x = 3'd0;
    endcase
    return x;
  endfunction

  function automatic logic [ODD_W-1:0] unit_odd(input logic [3:0] code);
    logic [ODD_W-1:0] o;
    case (code)
      UC_MINUTE:   o = ODD_W'(15);
      UC_HOUR:     o = ODD_W'(225);
      UC_DAY:      o = ODD_W'(675);
      UC_3HOUR:    o = ODD_W'(675);
      UC_6HOUR:    o = ODD_W'(675);
      UC_12HOUR:   o = ODD_W'(675);
      UC_QHOUR:    o = ODD_W'(225);
      UC_HALFHOUR: o = ODD_W'(225);
      default:     o = ODD_W'(1);
    endcase
    return o;
  endfunction

  // Inverse of the odd factor modulo 2^16.
  function automatic logic [15:0] unit_inv(input logic [3:0] code);
    logic [15:0] v;
    case (code)
      UC_MINUTE:   v = 16'd61167;
      UC_HOUR:     v = 16'd17185;
      UC_DAY:      v = 16'd49419;
      UC_3HOUR:    v = 16'd49419;
      UC_6HOUR:    v = 16'd49419;
      UC_12HOUR:   v = 16'd49419;
      UC_QHOUR:    v = 16'd17185;
      UC_HALFHOUR: v = 16'd17185;
      default:     v = 16'd1;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- design/gsus_datapath.sv -----
`default_nettype none
module gsus_datapath (
  input  wire logic           clk,
  input  wire gsus_pkg::in_t  in_data,
  input  wire gsus_pkg::cmd_t cmd,
  output gsus_pkg::sts_t      sts,
  output gsus_pkg::out_t      out_data
);

  logic [gsus_pkg::STEP_W-1:0] start_r;
  logic [gsus_pkg::STEP_W-1:0] end_r;
  logic [gsus_pkg::MUL_W-1:0]  mul_r;
  logic [15:0]                 lim_r;
  logic                        inst_r;
  logic [3:0]                  k_r;

  logic [gsus_pkg::SEC_W-1:0]  s_sec;
  logic [gsus_pkg::SEC_W-1:0]  e_sec;

  // Candidate check, first stage registers.
  logic [3:0]                  code1;
  logic [15:0]                 q_s1;
  logic [15:0]                 q_e1;
  logic [gsus_pkg::SEC_W-1:0]  t_s1;
  logic [gsus_pkg::SEC_W-1:0]  t_e1;
  logic                        low_ok_s1;
  logic                        low_ok_e1;
  logic [gsus_pkg::ODD_W-1:0]  odd1;

  gsus_pkg::out_t              res;
  gsus_pkg::out_t              out_r;

  logic [4:0]                  pos_sum;
  logic [3:0]                  pos;
  logic [3:0]                  code;
  logic [2:0]                  shift;
  logic [7:0]                  mask;
  logic [gsus_pkg::SEC_W-1:0]  t_s;
  logic [gsus_pkg::SEC_W-1:0]  t_e;
  logic [31:0]                 qs_prod;
  logic [31:0]                 qe_prod;
  logic [gsus_pkg::PROD_W-1:0] ps;
  logic [gsus_pkg::PROD_W-1:0] pe;
  logic                        hit_s;
  logic                        hit_e;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      start_r <= in_data.start_step;
      end_r   <= in_data.end_step;
      mul_r   <= gsus_pkg::step_secs(in_data.step_unit_code);
      lim_r   <= in_data.limit_value;
      inst_r  <= in_data.instant_mode;
      k_r     <= gsus_pkg::start_pos(in_data.current_unit);
    end
    if (cmd.mult) begin
      s_sec <= start_r * mul_r;
      e_sec <= end_r * mul_r;
    end
  end

  // Try 0 is always hour; try j walks the list from the start position, wrapping.
  always_comb begin
    pos_sum = 5'(k_r) + 5'(cmd.idx) - 5'd1;
    if (pos_sum >= 5'(gsus_pkg::CAND_COUNT)) begin
      pos = 4'(pos_sum - 5'(gsus_pkg::CAND_COUNT));
    end else begin
      pos = 4'(pos_sum);
    end
    code = (cmd.idx == 4'd0) ? gsus_pkg::UC_HOUR : gsus_pkg::cand_code(pos);
    shift = gsus_pkg::unit_shift(code);
    mask = 8'((8'd1 << shift) - 8'd1);
    t_s = s_sec >> shift;
    t_e = e_sec >> shift;
    // Exact division by the odd factor: the low 16 quotient bits come from
    // the modular inverse, and the second stage multiplies back to confirm.
    qs_prod = t_s[15:0] * gsus_pkg::unit_inv(code);
    qe_prod = t_e[15:0] * gsus_pkg::unit_inv(code);
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      code1     <= code;
      q_s1      <= qs_prod[15:0];
      q_e1      <= qe_prod[15:0];
      t_s1      <= t_s;
      t_e1      <= t_e;
      low_ok_s1 <= (s_sec[7:0] & mask) == 8'd0;
      low_ok_e1 <= (e_sec[7:0] & mask) == 8'd0;
      odd1      <= gsus_pkg::unit_odd(code);
    end
  end

  always_comb begin
    ps = q_s1 * odd1;
    pe = q_e1 * odd1;
    hit_s = low_ok_s1 && (t_s1 == {(gsus_pkg::SEC_W - gsus_pkg::PROD_W)'(0), ps})
            && (q_s1 <= lim_r);
    hit_e = low_ok_e1 && (t_e1 == {(gsus_pkg::SEC_W - gsus_pkg::PROD_W)'(0), pe})
            && (q_e1 <= lim_r);
    sts.hit = hit_s && (inst_r || hit_e);
    sts.unit_bad = (mul_r == '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.res_pass) begin
      res.status      <= 1'b0;
      res.chosen_unit <= code1;
      res.p1_value    <= q_s1;
      res.p2_value    <= inst_r ? 16'd0 : q_e1;
    end else if (cmd.res_fail) begin
      res.status      <= 1'b1;
      res.chosen_unit <= 4'd0;
      res.p1_value    <= 16'd0;
      res.p2_value    <= 16'd0;
    end
    if (cmd.out_load) begin
      out_r <= res;
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

// ----- design/gsus_ctrl.sv -----
`default_nettype none
module gsus_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  wire gsus_pkg::sts_t sts,
  output gsus_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_MULT   = 4'b0010,
    ST_SEARCH = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [3:0] j;
  logic [3:0] j_next;
  logic       chk;
  logic       chk_last;
  logic       out_valid_r;
  logic       out_valid_next;

  always_comb begin
    state_next = state;
    j_next = j;
    cmd = '0;
    cmd.idx = j;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_MULT;
        end
      end
      ST_MULT: begin
        cmd.mult = 1'b1;
        j_next = 4'd0;
        if (sts.unit_bad) begin
          cmd.res_fail = 1'b1;
          state_next = ST_DONE;
        end else begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        // The check of a try lands in the cycle after it is issued.
        if (chk && sts.hit) begin
          cmd.res_pass = 1'b1;
          state_next = ST_DONE;
        end else if (chk_last) begin
          cmd.res_fail = 1'b1;
          state_next = ST_DONE;
        end else if (j != gsus_pkg::CAND_COUNT) begin
          cmd.issue = 1'b1;
          j_next = 4'(j + 4'd1);
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      j           <= 4'd0;
      chk         <= 1'b0;
      chk_last    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state       <= state_next;
      j           <= j_next;
      chk         <= cmd.issue;
      chk_last    <= cmd.issue && (j == 4'(gsus_pkg::CAND_COUNT - 4'd1));
      out_valid_r <= out_valid_next;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_to_mult: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_MULT))
    else $error("accepted request did not start the multiply step");

  a_try_bound: assert property (@(posedge clk) disable iff (rst)
    j <= gsus_pkg::CAND_COUNT)
    else $error("try counter ran past the candidate list");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid_r) |-> $past(state == ST_DONE))
    else $error("result presented without a finished search");

  a_last_is_check: assert property (@(posedge clk) disable iff (rst)
    chk_last |-> (chk && state == ST_SEARCH))
    else $error("last-try flag set outside a pending check");

endmodule
`default_nettype wire

// ----- design/grib1_step_unit_search_unit.sv -----
// Channel | Direction | Handshake         | Payload
// in      | input     | in_valid/in_stall | gsus_pkg::in_t (steps, units, limit, instant)
// out     | output    | out_valid/out_stall | gsus_pkg::out_t (status, unit, P1, P2)
//
// A request with an undefined step unit fails in the multiply step; otherwise it is
// captured, its steps are multiplied to seconds, then tries run one per cycle
// through a two-stage exact-division check, and the result is posted.
// The search over ten candidate units sets the length; the first passing try ends it.
// A new request is taken as soon as the result moves to the output register,
// even while that result is still stalled. Reset is synchronous and clears control only.
`default_nettype none
module grib1_step_unit_search_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire gsus_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output gsus_pkg::out_t     out_data
);

  gsus_pkg::cmd_t cmd;
  gsus_pkg::sts_t sts;

  gsus_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  gsus_datapath u_datapath (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

// ----- sim/grib1_step_unit_search_unit_tb.sv -----
`default_nettype none

// Keeps the expected search results in request order and checks the block's results.
class unit_search_board;
  localparam int CAND_N = 10;

  gsus_pkg::out_t expected_units[$];
  int mismatches;
  int results_seen;

  function new();
    mismatches = 0;
    results_seen = 0;
  endfunction

  // Seconds per step unit code; zero for codes that have no length.
  static function logic [21:0] step_length(logic [3:0] code);
    case (code)
      gsus_pkg::UC_MINUTE:   return 22'd60;
      gsus_pkg::UC_HOUR:     return 22'd3600;
      gsus_pkg::UC_DAY:      return 22'd86400;
      gsus_pkg::UC_MONTH:    return 22'd2592000;
      gsus_pkg::UC_3HOUR:    return 22'd10800;
      gsus_pkg::UC_6HOUR:    return 22'd21600;
      gsus_pkg::UC_12HOUR:   return 22'd43200;
      gsus_pkg::UC_QHOUR:    return 22'd1;
      gsus_pkg::UC_HALFHOUR: return 22'd900;
      gsus_pkg::UC_SECOND:   return 22'd1800;
      default:               return 22'd0;
    endcase
  endfunction

  // Seconds per candidate unit; the last three codes differ from the step table.
  static function logic [21:0] cand_length(logic [3:0] code);
    case (code)
      gsus_pkg::UC_MINUTE:   return 22'd60;
      gsus_pkg::UC_HOUR:     return 22'd3600;
      gsus_pkg::UC_DAY:      return 22'd86400;
      gsus_pkg::UC_3HOUR:    return 22'd10800;
      gsus_pkg::UC_6HOUR:    return 22'd21600;
      gsus_pkg::UC_12HOUR:   return 22'd43200;
      gsus_pkg::UC_QHOUR:    return 22'd900;
      gsus_pkg::UC_HALFHOUR: return 22'd1800;
      gsus_pkg::UC_SECOND:   return 22'd1;
      default:               return 22'd0;
    endcase
  endfunction

  static function logic [3:0] cand_at(int pos);
    case (pos)
      0:       return gsus_pkg::UC_HOUR;
      1:       return gsus_pkg::UC_MINUTE;
      2:       return gsus_pkg::UC_3HOUR;
      3:       return gsus_pkg::UC_6HOUR;
      4:       return gsus_pkg::UC_12HOUR;
      5:       return gsus_pkg::UC_DAY;
      6:       return gsus_pkg::UC_MINUTE;
      7:       return gsus_pkg::UC_QHOUR;
      8:       return gsus_pkg::UC_HALFHOUR;
      default: return gsus_pkg::UC_SECOND;
    endcase
  endfunction

  static function gsus_pkg::out_t search_unit(gsus_pkg::in_t r);
    gsus_pkg::out_t res;
    logic [63:0] mul, s_sec, e_sec, d, lim;
    logic [3:0] code;
    int k;
    bit ok;
    res = '0;
    res.status = 1'b1;
    mul = 64'(step_length(r.step_unit_code));
    if (mul == 0) return res;
    // The search starts at the first listed position of the current unit.
    k = 0;
    for (int i = CAND_N - 1; i >= 0; i--) begin
      if ({4'd0, cand_at(i)} == r.current_unit) k = i;
    end
    s_sec = 64'(r.start_step) * mul;
    e_sec = 64'(r.end_step) * mul;
    lim = 64'(r.limit_value);
    for (int i = 0; i < CAND_N; i++) begin
      code = (i == 0) ? gsus_pkg::UC_HOUR : cand_at((k + i - 1) % CAND_N);
      d = 64'(cand_length(code));
      ok = (d != 0) && (s_sec % d == 0) && (s_sec / d <= lim);
      if (ok && !r.instant_mode) ok = (e_sec % d == 0) && (e_sec / d <= lim);
      if (ok) begin
        res.status = 1'b0;
        res.chosen_unit = code;
        res.p1_value = 16'(s_sec / d);
        res.p2_value = r.instant_mode ? 16'd0 : 16'(e_sec / d);
        return res;
      end
    end
    return res;
  endfunction

  function void note_request(gsus_pkg::in_t r);
    expected_units.push_back(search_unit(r));
  endfunction

  task report(string what);
    if (mismatches < 40) $display("search result %0d: %s", results_seen, what);
    mismatches++;
  endtask

  task check_result(gsus_pkg::out_t got);
    gsus_pkg::out_t exp_unit;
    if (expected_units.size() == 0) begin
      report("result arrived with no request pending");
    end else begin
      exp_unit = expected_units.pop_front();
      if (got.status !== exp_unit.status || got.chosen_unit !== exp_unit.chosen_unit ||
          got.p1_value !== exp_unit.p1_value || got.p2_value !== exp_unit.p2_value) begin
        report($sformatf("got status %0d unit %0d p1 %0d p2 %0d, expected %0d %0d %0d %0d",
                         got.status, got.chosen_unit, got.p1_value, got.p2_value,
                         exp_unit.status, exp_unit.chosen_unit, exp_unit.p1_value,
                         exp_unit.p2_value));
      end
    end
    results_seen++;
  endtask
endclass

module grib1_step_unit_search_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] UNDEF_LO = 4'd4;
  localparam logic [3:0] UNDEF_HI = 4'd9;
  localparam int REQ_PER_PHASE = 225;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  gsus_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  gsus_pkg::out_t out_data;

  int gap_pct = 0;
  int stall_pct = 0;
  unit_search_board board = new();

  initial begin
    forever #2 clk = ~clk;
  end

  grib1_step_unit_search_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always @(posedge clk) begin
    out_stall <= (stall_pct > 0) && (int'($urandom_range(99)) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) board.note_request(in_data);
      if (out_valid && !out_stall) board.check_result(out_data);
    end
  end

  function automatic longint unsigned gcd64(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic gsus_pkg::in_t make_req(logic [31:0] s, logic [31:0] e, logic [3:0] su,
                                             logic [7:0] cur, logic [15:0] lim, logic inst);
    gsus_pkg::in_t r;
    r.start_step = s;
    r.end_step = e;
    r.step_unit_code = su;
    r.current_unit = cur;
    r.limit_value = lim;
    r.instant_mode = inst;
    return r;
  endfunction

  // Maps 0..9 onto the step unit codes that have a defined length.
  function automatic logic [3:0] defined_unit(int idx);
    return (idx < 4) ? 4'(idx) : 4'(idx + 6);
  endfunction

  // Steps built so that they divide exactly in a randomly picked candidate unit,
  // with quotients around the limit so that both sides of the limit are hit.
  function automatic gsus_pkg::in_t shaped_request();
    gsus_pkg::in_t r;
    longint unsigned mul, stride, lim, q1, q2;
    r.step_unit_code = defined_unit($urandom_range(0, 9));
    mul = board.step_length(r.step_unit_code);
    stride = board.cand_length(board.cand_at($urandom_range(0, 9)));
    stride = stride / gcd64(stride, mul);
    case ($urandom_range(0, 3))
      0:       lim = 255;
      1:       lim = 65535;
      2:       lim = $urandom_range(1, 40);
      default: lim = $urandom_range(1, 65535);
    endcase
    q1 = $urandom_range(0, 32'(lim + lim / 8 + 1));
    case ($urandom_range(0, 2))
      0:       q2 = q1;
      1:       q2 = q1 + $urandom_range(0, 32'(lim / 4 + 1));
      default: q2 = $urandom_range(0, 32'(lim + lim / 8 + 1));
    endcase
    r.start_step = 32'(q1 * stride);
    r.end_step = 32'(q2 * stride);
    r.limit_value = 16'(lim);
    r.current_unit = ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                 : 8'(defined_unit($urandom_range(0, 9)));
    r.instant_mode = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic gsus_pkg::in_t random_request();
    gsus_pkg::in_t r;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 75) begin
      r = shaped_request();
    end else if (sel < 90) begin
      r = make_req($urandom, $urandom, 4'($urandom), 8'($urandom),
                   16'($urandom_range(1, 65535)), 1'($urandom));
    end else begin
      r = shaped_request();
      r.step_unit_code = 4'($urandom_range(UNDEF_LO, UNDEF_HI));
    end
    return r;
  endfunction

  // Holds the request on the bus until the block takes it.
  task automatic send_request(gsus_pkg::in_t r);
    while (gap_pct > 0 && int'($urandom_range(99)) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_request(make_req(0, 0, gsus_pkg::UC_HOUR, 8'(gsus_pkg::UC_HOUR), 16'd255, 1'b0));
    send_request(make_req(0, 0, UNDEF_LO, 8'(gsus_pkg::UC_HOUR), 16'd255, 1'b0));
    send_request(make_req('1, '1, UNDEF_HI, 8'hFF, 16'hFFFF, 1'b1));
    send_request(make_req('1, '1, gsus_pkg::UC_SECOND, 8'(gsus_pkg::UC_SECOND),
                          16'hFFFF, 1'b0));
    send_request(make_req(65535, 65535, gsus_pkg::UC_HOUR, 8'(gsus_pkg::UC_HOUR),
                          16'hFFFF, 1'b0));
    send_request(make_req(65536, 0, gsus_pkg::UC_HOUR, 8'(gsus_pkg::UC_HOUR),
                          16'hFFFF, 1'b1));
    // A zero limit lets only zero steps through.
    send_request(make_req(0, 0, gsus_pkg::UC_DAY, 8'(gsus_pkg::UC_DAY), 16'd0, 1'b0));
    send_request(make_req(1, 0, gsus_pkg::UC_DAY, 8'(gsus_pkg::UC_DAY), 16'd0, 1'b1));
    send_request(make_req(0, 1, gsus_pkg::UC_MINUTE, 8'(gsus_pkg::UC_MINUTE), 16'd0, 1'b0));
    send_request(make_req(6, 32'hDEADBEEF, gsus_pkg::UC_HOUR, 8'(gsus_pkg::UC_HOUR),
                          16'd255, 1'b1));
    // Current units outside the list start the search at the front; listed ones start at their position.
    send_request(make_req(30, 60, gsus_pkg::UC_MINUTE, 8'd200, 16'd255, 1'b0));
    send_request(make_req(30, 60, gsus_pkg::UC_MINUTE, 8'(gsus_pkg::UC_MONTH),
                          16'd255, 1'b0));
    send_request(make_req(30, 60, gsus_pkg::UC_MINUTE, 8'hFF, 16'd255, 1'b0));
    send_request(make_req(30, 60, gsus_pkg::UC_MINUTE, 8'(gsus_pkg::UC_MINUTE),
                          16'd255, 1'b0));
    send_request(make_req(30, 90, gsus_pkg::UC_MINUTE, 8'(gsus_pkg::UC_QHOUR),
                          16'd255, 1'b0));
    send_request(make_req(30, 90, gsus_pkg::UC_MINUTE, 8'(gsus_pkg::UC_HALFHOUR),
                          16'd255, 1'b0));
    send_request(make_req(30, 90, gsus_pkg::UC_MINUTE, 8'(gsus_pkg::UC_SECOND),
                          16'd255, 1'b0));
    send_request(make_req(0, 300, gsus_pkg::UC_HOUR, 8'(gsus_pkg::UC_3HOUR),
                          16'd255, 1'b0));
    send_request(make_req(1, 2, gsus_pkg::UC_QHOUR, 8'(gsus_pkg::UC_HOUR), 16'd255, 1'b0));
    send_request(make_req(1, 2, gsus_pkg::UC_MONTH, 8'(gsus_pkg::UC_DAY), 16'd255, 1'b0));
    send_request(make_req(3, 5, gsus_pkg::UC_HALFHOUR, 8'(gsus_pkg::UC_HALFHOUR),
                          16'd255, 1'b0));
    send_request(make_req(1, 3, gsus_pkg::UC_12HOUR, 8'(gsus_pkg::UC_12HOUR),
                          16'd2, 1'b0));
    send_request(make_req(4, 8, gsus_pkg::UC_6HOUR, 8'(gsus_pkg::UC_6HOUR),
                          16'hFFFF, 1'b0));

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 54; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 54; end
        default: begin gap_pct = 26; stall_pct = 26; end
      endcase
      repeat (REQ_PER_PHASE) send_request(random_request());
    end
    in_valid <= 1'b0;

    while (board.expected_units.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("grib1_step_unit_search_unit: match");
    end else begin
      $display("grib1_step_unit_search_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("grib1_step_unit_search_unit: mismatch");
    $finish;
  end
endmodule
`default_nettype wire

// ----- sim.f -----
design/gsus_pkg.sv
design/gsus_datapath.sv
design/gsus_ctrl.sv
design/grib1_step_unit_search_unit.sv
sim/grib1_step_unit_search_unit_tb.sv
